// ----- rtl/lssc_pkg.sv -----
// Package for the lidar sector side compare block.
// Holds the configuration, job and result types and the fixed constants.
// Used by every module under rtl; depends on nothing.
package lssc_pkg;

    localparam int unsigned INDEX_W    = 12;
    localparam int unsigned RANGE_W    = 16;
    localparam int unsigned SUM_W      = 28;
    localparam int unsigned COUNT_W    = 13;
    localparam int unsigned MIN_W      = 17;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PROD_W     = SUM_W + COUNT_W;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [MIN_W-1:0]   MIN_START = 17'd100000;
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [INDEX_W-1:0] LEFT_FIRST_RESET  = 12'd350;
    localparam logic [INDEX_W-1:0] LEFT_LAST_RESET   = 12'd527;
    localparam logic [INDEX_W-1:0] RIGHT_FIRST_RESET = 12'd529;
    localparam logic [RANGE_W-1:0] RANGE_LIMIT_RESET = 16'd12000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEFT_FIRST  = 2'd0,
        REG_LEFT_LAST   = 2'd1,
        REG_RIGHT_FIRST = 2'd2,
        REG_RANGE_LIMIT = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [INDEX_W-1:0] left_first;
        logic [INDEX_W-1:0] left_last;
        logic [INDEX_W-1:0] right_first;
        logic [RANGE_W-1:0] range_limit;
    } t_cfg;

    // Totals of one finished scan, handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0]   left_sum;
        logic [SUM_W-1:0]   right_sum;
        logic [COUNT_W-1:0] left_tally;
        logic [COUNT_W-1:0] right_tally;
        logic [MIN_W-1:0]   left_floor;
        logic [MIN_W-1:0]   right_floor;
    } t_job;

    typedef struct packed {
        logic             left_side;
        logic [MIN_W-1:0] left_floor;
        logic [MIN_W-1:0] right_floor;
    } t_result;

endpackage

// ----- rtl/lssc_fifo.sv -----
// Small synchronous queue used between the front, the back and the result port.
// Depends on lssc_pkg for the queue depth.
module lssc_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned DEPTH = lssc_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/lssc_front.sv -----
// Front part: counts sample indexes, sorts samples into the windows and
// accumulates sums, counts and minima; emits one job per scan. Uses lssc_pkg.
module lssc_front #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lssc_pkg::t_cfg                i_cfg,
    input  logic                          i_accept,
    input  logic [lssc_pkg::RANGE_W-1:0]  i_range_mm,
    input  logic                          i_last,
    output logic                          o_job_push,
    output lssc_pkg::t_job                o_job
);
    localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
    localparam int unsigned CMP_W = (IDX_W > lssc_pkg::INDEX_W) ? IDX_W : lssc_pkg::INDEX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

    logic [IDX_W-1:0]             r_index;
    lssc_pkg::t_job               r_acc;
    lssc_pkg::t_job               n_acc;
    logic [CMP_W-1:0]             idx_cmp;
    logic                         in_left;
    logic                         in_right;
    logic                         valid;
    logic [lssc_pkg::SUM_W:0]     sum_ext;
    logic [lssc_pkg::SUM_W-1:0]   sum_sat;
    logic [lssc_pkg::SUM_W-1:0]   win_sum;
    logic [lssc_pkg::COUNT_W-1:0] win_count;
    logic [lssc_pkg::MIN_W-1:0]   win_min;
    logic [lssc_pkg::MIN_W-1:0]   range_ext;
    logic [lssc_pkg::SUM_W-1:0]   upd_sum;
    logic [lssc_pkg::COUNT_W-1:0] upd_count;
    logic [lssc_pkg::MIN_W-1:0]   upd_min;

    assign idx_cmp  = CMP_W'(r_index);
    // An index inside both windows belongs to the left one only.
    assign in_left  = (idx_cmp >= CMP_W'(i_cfg.left_first)) &&
                      (idx_cmp <= CMP_W'(i_cfg.left_last));
    assign in_right = !in_left && (idx_cmp >= CMP_W'(i_cfg.right_first));
    assign valid    = (i_range_mm != '0) && (i_range_mm < i_cfg.range_limit);

    assign win_sum   = in_left ? r_acc.left_sum    : r_acc.right_sum;
    assign win_count = in_left ? r_acc.left_tally  : r_acc.right_tally;
    assign win_min   = in_left ? r_acc.left_floor  : r_acc.right_floor;
    assign range_ext = lssc_pkg::MIN_W'(i_range_mm);

    assign sum_ext   = {1'b0, win_sum} + (lssc_pkg::SUM_W + 1)'(i_range_mm);
    assign sum_sat   = sum_ext[lssc_pkg::SUM_W] ? lssc_pkg::SUM_MAX
                                                : sum_ext[lssc_pkg::SUM_W-1:0];
    assign upd_sum   = valid ? sum_sat : win_sum;
    assign upd_count = (valid && (win_count != lssc_pkg::COUNT_MAX)) ? win_count + 1'b1
                                                                     : win_count;
    assign upd_min   = (range_ext < win_min) ? range_ext : win_min;

    always_comb begin
        n_acc = r_acc;
        if (in_left) begin
            n_acc.left_sum   = upd_sum;
            n_acc.left_tally = upd_count;
            n_acc.left_floor = upd_min;
        end else if (in_right) begin
            n_acc.right_sum   = upd_sum;
            n_acc.right_tally = upd_count;
            n_acc.right_floor = upd_min;
        end
    end

    assign o_job_push = i_accept && i_last;
    assign o_job      = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_index           <= '0;
            r_acc.left_sum    <= '0;
            r_acc.right_sum   <= '0;
            r_acc.left_tally  <= '0;
            r_acc.right_tally <= '0;
            r_acc.left_floor  <= lssc_pkg::MIN_START;
            r_acc.right_floor <= lssc_pkg::MIN_START;
        end else if (i_accept) begin
            r_index <= (r_index == IDX_LAST) ? r_index : r_index + 1'b1;
            r_acc   <= n_acc;
        end
    end

endmodule

// ----- rtl/lssc_back.sv -----
// Back part: compares the two window means by cross-multiplication, with the
// products registered, and pushes results to the output queue. Uses lssc_pkg.
module lssc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lssc_pkg::t_job     i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output lssc_pkg::t_result  o_res
);
    logic                         r_valid;
    logic [lssc_pkg::PROD_W-1:0]  r_lhs;
    logic [lssc_pkg::PROD_W-1:0]  r_rhs;
    logic                         r_zero;
    logic [lssc_pkg::MIN_W-1:0]   r_left_floor;
    logic [lssc_pkg::MIN_W-1:0]   r_right_floor;
    logic                         advance;

    // The product stage moves on whenever the result queue can take its beat.
    assign advance    = !r_valid || !i_res_full;
    assign o_job_pop  = !i_job_empty && advance;
    assign o_res_push = r_valid && !i_res_full;

    assign o_res.left_side   = r_zero || (r_lhs < r_rhs);
    assign o_res.left_floor  = r_left_floor;
    assign o_res.right_floor = r_right_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= !i_job_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_lhs <= lssc_pkg::PROD_W'(i_job.left_sum) * lssc_pkg::PROD_W'(i_job.right_tally);
            r_rhs <= lssc_pkg::PROD_W'(i_job.right_sum) * lssc_pkg::PROD_W'(i_job.left_tally);
            r_zero        <= (i_job.left_tally == '0) || (i_job.right_tally == '0);
            r_left_floor  <= i_job.left_floor;
            r_right_floor <= i_job.right_floor;
        end
    end

endmodule

// ----- rtl/lidar_sector_side_compare.sv -----
// Top level of the lidar sector side compare block.
// Holds the configuration registers and joins front, back and the queues;
// depends on lssc_pkg, lssc_fifo, lssc_front and lssc_back.
//
// Usage: range samples of one scan enter on the input queue port, one beat
// per sample (i_push while o_full is low), with i_last on the final sample.
// Every scan yields exactly one result beat on the output queue port: the
// nearer side and the minima of both windows, held while o_empty is low and
// taken with i_pop. Samples are accepted one per cycle while o_full is low;
// the front registers the per-sample accumulate and minimum.
// A result reaches the output through the job queue, the multiply stage
// and the result queue, in that order; the result queue then holds it
// until i_pop takes it.
// Scans may be as short as one sample each; results then leave at one per
// cycle while the receiver pops each one. When it stalls, the result queue
// and then the job queue fill, and o_full rises once the job queue is full;
// every sample, the last of a scan too, flows in only while o_full is low.
// Configuration writes take effect from the next sample. Reset restores
// the register defaults, clears the scan totals and empties both queues.
module lidar_sector_side_compare #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lssc_pkg::CFG_ADDR_W-1:0]  i_cfg_index,
    input  logic [lssc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [lssc_pkg::RANGE_W-1:0]     i_range_mm,
    input  logic                             i_last,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic                             o_left_side,
    output logic                             o_right_side,
    output logic [lssc_pkg::MIN_W-1:0]       o_left_min_mm,
    output logic [lssc_pkg::MIN_W-1:0]       o_right_min_mm
);
    lssc_pkg::t_cfg    r_cfg;
    lssc_pkg::t_job    front_job;
    lssc_pkg::t_job    back_job;
    lssc_pkg::t_result back_res;
    lssc_pkg::t_result out_res;
    logic              accept;
    logic              job_push;
    logic              job_full;
    logic              job_empty;
    logic              job_pop;
    logic              res_push;
    logic              res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_first  <= lssc_pkg::LEFT_FIRST_RESET;
            r_cfg.left_last   <= lssc_pkg::LEFT_LAST_RESET;
            r_cfg.right_first <= lssc_pkg::RIGHT_FIRST_RESET;
            r_cfg.range_limit <= lssc_pkg::RANGE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (lssc_pkg::t_reg_index'(i_cfg_index))
                lssc_pkg::REG_LEFT_FIRST:
                    r_cfg.left_first  <= i_cfg_wdata[lssc_pkg::INDEX_W-1:0];
                lssc_pkg::REG_LEFT_LAST:
                    r_cfg.left_last   <= i_cfg_wdata[lssc_pkg::INDEX_W-1:0];
                lssc_pkg::REG_RIGHT_FIRST:
                    r_cfg.right_first <= i_cfg_wdata[lssc_pkg::INDEX_W-1:0];
                lssc_pkg::REG_RANGE_LIMIT:
                    r_cfg.range_limit <= i_cfg_wdata[lssc_pkg::RANGE_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_full = job_full;
    assign accept = i_push && !job_full;

    lssc_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_range_mm (i_range_mm),
        .i_last     (i_last),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    lssc_fifo #(
        .WIDTH ($bits(lssc_pkg::t_job))
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (front_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (back_job),
        .o_empty (job_empty)
    );

    lssc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (back_job),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    lssc_fifo #(
        .WIDTH ($bits(lssc_pkg::t_result))
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (out_res),
        .o_empty (o_empty)
    );

    assign o_left_side    = out_res.left_side;
    assign o_right_side   = !out_res.left_side;
    assign o_left_min_mm  = out_res.left_floor;
    assign o_right_min_mm = out_res.right_floor;

`ifndef NO_ASSERTIONS
    // A sample that does not end a scan never produces a job.
    a_no_job_midscan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_last) |-> !job_push)
        else $error("job pushed for a sample without the last flag");

    // The back never pushes a result into a full result queue.
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // A job popped from the queue shows up in the product stage in the next cycle.
    a_job_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_pop && !res_full) |=> (u_back.r_valid))
        else $error("popped job lost before the product stage");

    // Right after reset there is no result waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n) |-> o_empty)
        else $error("result queue not empty after reset");
`endif

endmodule
